>>> rtl/abkf_pkg.sv
// shared types, constants and saturation helper of the angle and bias kalman filter
package abkf_pkg;

   localparam int VAL_W             = 48;
   localparam int CFG_W             = 47;
   localparam int CSR_IDX_W         = 2;
   localparam int FRAC_BITS_DEFAULT = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ANGLE_NOISE,
      CSR_BIAS_NOISE,
      CSR_MEAS_NOISE,
      CSR_PERIOD
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      SP_ANGLE,
      SP_COV_AA,
      SP_COV_AB,
      SP_COV_BB,
      SU_COV_AA,
      SU_COV_AB,
      SU_COV_BA,
      SU_COV_BB,
      SU_ANGLE,
      SU_BIAS
   } step_type;

   typedef struct packed {
      logic                    start;
      logic signed [VAL_W-1:0] a;
      logic signed [VAL_W-1:0] b;
   } op_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [VAL_W-1:0] result;
   } op_rsp_type;

   function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [VAL_W+1:0] v);
      logic signed [VAL_W+1:0] vmax;
      logic signed [VAL_W+1:0] vmin;
      vmax = $signed({3'b000, {(VAL_W-1){1'b1}}});
      vmin = $signed({3'b111, {(VAL_W-1){1'b0}}});
      if (v > vmax) begin
         sat_val = vmax[VAL_W-1:0];
      end else if (v < vmin) begin
         sat_val = vmin[VAL_W-1:0];
      end else begin
         sat_val = v[VAL_W-1:0];
      end
   endfunction

   function automatic logic signed [VAL_W+1:0] ext_val(input logic signed [VAL_W-1:0] v);
      ext_val = {{2{v[VAL_W-1]}}, v};
   endfunction

endpackage

>>> rtl/abkf_if.sv
// request, response and register write channel interfaces
interface abkf_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [abkf_pkg::VAL_W-1:0]    measured_angle;
   logic signed [abkf_pkg::VAL_W-1:0]    gyro_rate;
   modport source (output valid, measured_angle, gyro_rate, input ready);
   modport sink   (input valid, measured_angle, gyro_rate, output ready);
endinterface

interface abkf_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [abkf_pkg::VAL_W-1:0]    angle_estimate;
   logic signed [abkf_pkg::VAL_W-1:0]    corrected_rate;
   modport source (output valid, angle_estimate, corrected_rate, input ready);
   modport sink   (input valid, angle_estimate, corrected_rate, output ready);
endinterface

interface abkf_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [abkf_pkg::CSR_IDX_W-1:0]       index;
   logic [abkf_pkg::CFG_W-1:0]           data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/abkf_mul.sv
// iterative fixed point multiplier built on one 24x24 partial product unit
module abkf_mul #(
   parameter int FRAC_BITS = abkf_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  abkf_pkg::op_req_type   op_req,
   output abkf_pkg::op_rsp_type   op_rsp
);

   localparam int VW = abkf_pkg::VAL_W;
   localparam int HW = VW / 2;
   localparam int PW = 2 * VW;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [2:0]           cnt_ff, cnt_in;
   logic [VW-1:0]        ma_ff, ma_in;
   logic [VW-1:0]        mb_ff, mb_in;
   logic                 neg_ff, neg_in;
   logic [PW-1:0]        acc_ff, acc_in;
   logic signed [VW-1:0] res_ff, res_in;

   logic [HW-1:0]        ah, bh;
   logic [VW-1:0]        pp;
   logic [PW-1:0]        pp_ext;
   logic [1:0]           pos;
   logic signed [PW:0]   sp;
   logic signed [PW:0]   sh;
   logic signed [PW:0]   pmax, pmin;

   always_comb begin
      ah     = cnt_ff[1] ? ma_ff[VW-1:HW] : ma_ff[HW-1:0];
      bh     = cnt_ff[0] ? mb_ff[VW-1:HW] : mb_ff[HW-1:0];
      pp     = VW'(ah) * VW'(bh);
      pos    = 2'(cnt_ff[1]) + 2'(cnt_ff[0]);
      case (pos)
         2'd0:    pp_ext = {{VW{1'b0}}, pp};
         2'd1:    pp_ext = {{HW{1'b0}}, pp, {HW{1'b0}}};
         2'd2:    pp_ext = {pp, {VW{1'b0}}};
         default: pp_ext = '0;
      endcase
      sp   = neg_ff ? -$signed({1'b0, acc_ff}) : $signed({1'b0, acc_ff});
      sh   = sp >>> FRAC_BITS;
      pmax = $signed({{(PW-VW+2){1'b0}}, {(VW-1){1'b1}}});
      pmin = $signed({{(PW-VW+2){1'b1}}, {(VW-1){1'b0}}});

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      ma_in   = ma_ff;
      mb_in   = mb_ff;
      neg_in  = neg_ff;
      acc_in  = acc_ff;
      res_in  = res_ff;
      if (op_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         acc_in  = '0;
         neg_in  = op_req.a[VW-1] ^ op_req.b[VW-1];
         ma_in   = op_req.a[VW-1] ? VW'(-op_req.a) : VW'(op_req.a);
         mb_in   = op_req.b[VW-1] ? VW'(-op_req.b) : VW'(op_req.b);
      end else if (busy_ff) begin
         if (cnt_ff == 3'd4) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (sh > pmax) begin
               res_in = pmax[VW-1:0];
            end else if (sh < pmin) begin
               res_in = pmin[VW-1:0];
            end else begin
               res_in = sh[VW-1:0];
            end
         end else begin
            acc_in = acc_ff + pp_ext;
            cnt_in = cnt_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      ma_ff  <= ma_in;
      mb_ff  <= mb_in;
      neg_ff <= neg_in;
      acc_ff <= acc_in;
      res_ff <= res_in;
   end

   assign op_rsp.done   = done_ff;
   assign op_rsp.result = res_ff;

endmodule

>>> rtl/abkf_div.sv
// bit serial restoring divider for the fixed point gain quotient
module abkf_div #(
   parameter int FRAC_BITS = abkf_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  abkf_pkg::op_req_type   op_req,
   output abkf_pkg::op_rsp_type   op_rsp
);

   localparam int VW = abkf_pkg::VAL_W;
   localparam int DW = VW + FRAC_BITS;
   localparam int CW = $clog2(DW + 1);
   localparam int QW = VW + 2;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [DW-1:0]        dvd_ff, dvd_in;
   logic [VW-1:0]        ud_ff, ud_in;
   logic [VW-1:0]        rem_ff, rem_in;
   logic [QW-1:0]        q_ff, q_in;
   logic                 neg_ff, neg_in;
   logic signed [VW-1:0] res_ff, res_in;

   logic [VW:0]          r2;
   logic                 ge;
   logic [VW:0]          r_sub;
   logic [QW-1:0]        q2;
   logic [QW-1:0]        lim_neg, lim_pos;
   logic [VW-1:0]        un;
   logic signed [VW-1:0] vmax, vmin;

   always_comb begin
      lim_neg = {2'b00, 1'b1, {(VW-1){1'b0}}};
      lim_pos = {3'b000, {(VW-1){1'b1}}};
      vmax    = $signed({1'b0, {(VW-1){1'b1}}});
      vmin    = $signed({1'b1, {(VW-1){1'b0}}});
      r2      = {rem_ff, dvd_ff[DW-1]};
      ge      = r2 >= {1'b0, ud_ff};
      r_sub   = r2 - {1'b0, ud_ff};
      q2      = {q_ff[QW-2:0], ge};
      un      = op_req.a[VW-1] ? VW'(-op_req.a) : VW'(op_req.a);

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      ud_in   = ud_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      neg_in  = neg_ff;
      res_in  = res_ff;
      if (op_req.start) begin
         if (op_req.b == '0) begin
            done_in = 1'b1;
            if (op_req.a == '0) begin
               res_in = '0;
            end else if (op_req.a[VW-1]) begin
               res_in = vmin;
            end else begin
               res_in = vmax;
            end
         end else begin
            busy_in = 1'b1;
            cnt_in  = '0;
            dvd_in  = {un, {FRAC_BITS{1'b0}}};
            ud_in   = op_req.b[VW-1] ? VW'(-op_req.b) : VW'(op_req.b);
            rem_in  = '0;
            q_in    = '0;
            neg_in  = op_req.a[VW-1] ^ op_req.b[VW-1];
         end
      end else if (busy_ff) begin
         if (cnt_ff == CW'(DW)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (neg_ff) begin
               res_in = (q_ff > lim_neg) ? vmin : VW'(-q_ff[VW-1:0]);
            end else begin
               res_in = (q_ff > lim_pos) ? vmax : $signed(q_ff[VW-1:0]);
            end
         end else begin
            rem_in = ge ? r_sub[VW-1:0] : r2[VW-1:0];
            q_in   = (q2 > lim_neg) ? lim_neg + QW'(1) : q2;
            dvd_in = {dvd_ff[DW-2:0], 1'b0};
            cnt_in = cnt_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      ud_ff  <= ud_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
   end

   assign op_rsp.done   = done_ff;
   assign op_rsp.result = res_ff;

endmodule

>>> rtl/angle_bias_kalman_filter.sv
// two state angle and gyro bias kalman filter, sequenced over a shared multiplier and divider
//
//   channel   dir   handshake      payload
//   req_bus   in    valid/ready    measured_angle, gyro_rate
//   rsp_bus   out   valid/ready    angle_estimate, corrected_rate
//   csr_bus   in    valid/ready    index, data
//
// one request runs ten products through the 24x24 multiplier and two gain quotients
// through the bit serial divider
// req_ready is high only while idle; a finished response waits in its output register
// reset clears state to zero angle and bias, identity covariance and default noise settings
module angle_bias_kalman_filter #(
   parameter int FRAC_BITS = abkf_pkg::FRAC_BITS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   abkf_req_if.sink      req_bus,
   abkf_rsp_if.source    rsp_bus,
   abkf_csr_if.sink      csr_bus
);

   localparam int VW = abkf_pkg::VAL_W;
   localparam int CF = abkf_pkg::CFG_W;
   localparam logic [63:0] QA_RESET = ((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000;
   localparam logic [63:0] QB_RESET = ((64'd3 << FRAC_BITS) + 64'd500) / 64'd1000;
   localparam logic [63:0] R_RESET  = 64'd20 << FRAC_BITS;
   localparam logic [63:0] DT_RESET = ((64'd5 << FRAC_BITS) + 64'd500) / 64'd1000;
   localparam logic [63:0] ONE      = 64'd1 << FRAC_BITS;

   abkf_pkg::state_type  state_ff, state_in;
   abkf_pkg::step_type   step_ff, step_in;
   logic                 issued_ff, issued_in;
   logic                 div_sel_ff, div_sel_in;

   logic [CF-1:0]        qa_ff, qb_ff, r_ff, dt_ff;
   logic signed [VW-1:0] angle_ff, angle_in;
   logic signed [VW-1:0] bias_ff, bias_in;
   logic signed [VW-1:0] paa_ff, paa_in;
   logic signed [VW-1:0] pab_ff, pab_in;
   logic signed [VW-1:0] pba_ff, pba_in;
   logic signed [VW-1:0] pbb_ff, pbb_in;
   logic signed [VW-1:0] meas_ff, meas_in;
   logic signed [VW-1:0] gyro_ff, gyro_in;
   logic signed [VW-1:0] t0_ff, t0_in;
   logic signed [VW-1:0] t1_ff, t1_in;
   logic signed [VW-1:0] err_ff, err_in;
   logic signed [VW-1:0] k0_ff, k0_in;
   logic signed [VW-1:0] k1_ff, k1_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [VW-1:0] rsp_angle_ff, rsp_angle_in;
   logic signed [VW-1:0] rsp_rate_ff, rsp_rate_in;

   abkf_pkg::op_req_type mul_req, div_req;
   abkf_pkg::op_rsp_type mul_rsp, div_rsp;

   logic signed [VW-1:0] dt_val, p;
   logic signed [VW-1:0] den;
   logic                 req_fire;

   abkf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock  (clock),
      .reset  (reset),
      .op_req (mul_req),
      .op_rsp (mul_rsp)
   );

   abkf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock  (clock),
      .reset  (reset),
      .op_req (div_req),
      .op_rsp (div_rsp)
   );

   // register writes
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         qa_ff <= QA_RESET[CF-1:0];
         qb_ff <= QB_RESET[CF-1:0];
         r_ff  <= R_RESET[CF-1:0];
         dt_ff <= DT_RESET[CF-1:0];
      end else if (csr_bus.valid) begin
         case (abkf_pkg::csr_index_type'(csr_bus.index))
            abkf_pkg::CSR_ANGLE_NOISE: qa_ff <= csr_bus.data;
            abkf_pkg::CSR_BIAS_NOISE:  qb_ff <= csr_bus.data;
            abkf_pkg::CSR_MEAS_NOISE:  r_ff  <= csr_bus.data;
            abkf_pkg::CSR_PERIOD:      dt_ff <= csr_bus.data;
            default: ;
         endcase
      end
   end

   assign req_bus.ready = (state_ff == abkf_pkg::ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;

   // operand selection, sequencing and write back
   always_comb begin
      dt_val = $signed({1'b0, dt_ff});
      p      = mul_rsp.result;
      den    = abkf_pkg::sat_val($signed({3'b000, r_ff}) + abkf_pkg::ext_val(paa_ff));

      mul_req.start = 1'b0;
      mul_req.b     = dt_val;
      case (step_ff)
         abkf_pkg::SP_ANGLE:
            mul_req.a = abkf_pkg::sat_val(abkf_pkg::ext_val(gyro_ff)
                                          - abkf_pkg::ext_val(bias_ff));
         abkf_pkg::SP_COV_AA:
            mul_req.a = abkf_pkg::sat_val($signed({3'b000, qa_ff})
                                          - abkf_pkg::ext_val(pab_ff)
                                          - abkf_pkg::ext_val(pba_ff));
         abkf_pkg::SP_COV_AB:
            mul_req.a = abkf_pkg::sat_val(-abkf_pkg::ext_val(pbb_ff));
         abkf_pkg::SP_COV_BB:
            mul_req.a = $signed({1'b0, qb_ff});
         abkf_pkg::SU_COV_AA: begin
            mul_req.a = k0_ff;
            mul_req.b = t0_ff;
         end
         abkf_pkg::SU_COV_AB: begin
            mul_req.a = k0_ff;
            mul_req.b = t1_ff;
         end
         abkf_pkg::SU_COV_BA: begin
            mul_req.a = k1_ff;
            mul_req.b = t0_ff;
         end
         abkf_pkg::SU_COV_BB: begin
            mul_req.a = k1_ff;
            mul_req.b = t1_ff;
         end
         abkf_pkg::SU_ANGLE: begin
            mul_req.a = k0_ff;
            mul_req.b = err_ff;
         end
         abkf_pkg::SU_BIAS: begin
            mul_req.a = k1_ff;
            mul_req.b = err_ff;
         end
         default: mul_req.a = '0;
      endcase

      div_req.start = 1'b0;
      div_req.a     = div_sel_ff ? pba_ff : paa_ff;
      div_req.b     = den;

      state_in     = state_ff;
      step_in      = step_ff;
      issued_in    = issued_ff;
      div_sel_in   = div_sel_ff;
      angle_in     = angle_ff;
      bias_in      = bias_ff;
      paa_in       = paa_ff;
      pab_in       = pab_ff;
      pba_in       = pba_ff;
      pbb_in       = pbb_ff;
      meas_in      = meas_ff;
      gyro_in      = gyro_ff;
      t0_in        = t0_ff;
      t1_in        = t1_ff;
      err_in       = err_ff;
      k0_in        = k0_ff;
      k1_in        = k1_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_angle_in = rsp_angle_ff;
      rsp_rate_in  = rsp_rate_ff;

      case (state_ff)
         abkf_pkg::ST_IDLE: begin
            if (req_fire) begin
               meas_in   = req_bus.measured_angle;
               gyro_in   = req_bus.gyro_rate;
               step_in   = abkf_pkg::SP_ANGLE;
               issued_in = 1'b0;
               state_in  = abkf_pkg::ST_MUL;
            end
         end
         abkf_pkg::ST_MUL: begin
            if (!issued_ff) begin
               mul_req.start = 1'b1;
               issued_in     = 1'b1;
            end else if (mul_rsp.done) begin
               issued_in = 1'b0;
               step_in   = abkf_pkg::step_type'(step_ff + 4'd1);
               case (step_ff)
                  abkf_pkg::SP_ANGLE:
                     angle_in = abkf_pkg::sat_val(abkf_pkg::ext_val(angle_ff)
                                                  + abkf_pkg::ext_val(p));
                  abkf_pkg::SP_COV_AA:
                     paa_in = abkf_pkg::sat_val(abkf_pkg::ext_val(paa_ff)
                                                + abkf_pkg::ext_val(p));
                  abkf_pkg::SP_COV_AB: begin
                     pab_in = abkf_pkg::sat_val(abkf_pkg::ext_val(pab_ff)
                                                + abkf_pkg::ext_val(p));
                     pba_in = abkf_pkg::sat_val(abkf_pkg::ext_val(pba_ff)
                                                + abkf_pkg::ext_val(p));
                  end
                  abkf_pkg::SP_COV_BB: begin
                     pbb_in     = abkf_pkg::sat_val(abkf_pkg::ext_val(pbb_ff)
                                                    + abkf_pkg::ext_val(p));
                     t0_in      = paa_ff;
                     t1_in      = pab_ff;
                     err_in     = abkf_pkg::sat_val(abkf_pkg::ext_val(meas_ff)
                                                    - abkf_pkg::ext_val(angle_ff));
                     div_sel_in = 1'b0;
                     state_in   = abkf_pkg::ST_DIV;
                  end
                  abkf_pkg::SU_COV_AA:
                     paa_in = abkf_pkg::sat_val(abkf_pkg::ext_val(paa_ff)
                                                - abkf_pkg::ext_val(p));
                  abkf_pkg::SU_COV_AB:
                     pab_in = abkf_pkg::sat_val(abkf_pkg::ext_val(pab_ff)
                                                - abkf_pkg::ext_val(p));
                  abkf_pkg::SU_COV_BA:
                     pba_in = abkf_pkg::sat_val(abkf_pkg::ext_val(pba_ff)
                                                - abkf_pkg::ext_val(p));
                  abkf_pkg::SU_COV_BB:
                     pbb_in = abkf_pkg::sat_val(abkf_pkg::ext_val(pbb_ff)
                                                - abkf_pkg::ext_val(p));
                  abkf_pkg::SU_ANGLE:
                     angle_in = abkf_pkg::sat_val(abkf_pkg::ext_val(angle_ff)
                                                  + abkf_pkg::ext_val(p));
                  abkf_pkg::SU_BIAS: begin
                     bias_in  = abkf_pkg::sat_val(abkf_pkg::ext_val(bias_ff)
                                                  + abkf_pkg::ext_val(p));
                     step_in  = abkf_pkg::SP_ANGLE;
                     state_in = abkf_pkg::ST_DONE;
                  end
                  default: state_in = abkf_pkg::ST_IDLE;
               endcase
            end
         end
         abkf_pkg::ST_DIV: begin
            if (!issued_ff) begin
               div_req.start = 1'b1;
               issued_in     = 1'b1;
            end else if (div_rsp.done) begin
               issued_in = 1'b0;
               if (div_sel_ff) begin
                  k1_in    = div_rsp.result;
                  step_in  = abkf_pkg::SU_COV_AA;
                  state_in = abkf_pkg::ST_MUL;
               end else begin
                  k0_in      = div_rsp.result;
                  div_sel_in = 1'b1;
               end
            end
         end
         abkf_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_angle_in = angle_ff;
               rsp_rate_in  = abkf_pkg::sat_val(abkf_pkg::ext_val(gyro_ff)
                                                - abkf_pkg::ext_val(bias_ff));
               state_in     = abkf_pkg::ST_IDLE;
            end
         end
         default: state_in = abkf_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= abkf_pkg::ST_IDLE;
         step_ff      <= abkf_pkg::SP_ANGLE;
         issued_ff    <= 1'b0;
         div_sel_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         angle_ff     <= '0;
         bias_ff      <= '0;
         paa_ff       <= $signed(ONE[VW-1:0]);
         pab_ff       <= '0;
         pba_ff       <= '0;
         pbb_ff       <= $signed(ONE[VW-1:0]);
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         issued_ff    <= issued_in;
         div_sel_ff   <= div_sel_in;
         rsp_valid_ff <= rsp_valid_in;
         angle_ff     <= angle_in;
         bias_ff      <= bias_in;
         paa_ff       <= paa_in;
         pab_ff       <= pab_in;
         pba_ff       <= pba_in;
         pbb_ff       <= pbb_in;
      end
      meas_ff      <= meas_in;
      gyro_ff      <= gyro_in;
      t0_ff        <= t0_in;
      t1_ff        <= t1_in;
      err_ff       <= err_in;
      k0_ff        <= k0_in;
      k1_ff        <= k1_in;
      rsp_angle_ff <= rsp_angle_in;
      rsp_rate_ff  <= rsp_rate_in;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.angle_estimate = rsp_angle_ff;
   assign rsp_bus.corrected_rate = rsp_rate_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == abkf_pkg::ST_MUL) && (step_ff == abkf_pkg::SP_ANGLE))
      else $error("request did not start the predict sequence");

   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mul_rsp.done && div_rsp.done))
      else $error("multiplier and divider finished together");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == abkf_pkg::ST_DONE))
      else $error("response raised outside the done state");

   a_div_only_in_div: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> (state_ff == abkf_pkg::ST_DIV) && !mul_req.start)
      else $error("divider started outside the gain step");

endmodule

>>> tb/sv/tb.sv
// self-checking testbench of the angle and gyro bias kalman filter
module tb;

   typedef logic signed [abkf_pkg::VAL_W-1:0] val_type;
   typedef logic signed [127:0] wide_type;
   typedef struct packed {
      val_type angle;
      val_type rate;
   } estimate_type;
   typedef struct {
      val_type      meas;
      val_type      gyro;
      bit           typed;
      estimate_type want;
   } stim_row_type;

   localparam int      FRAC     = abkf_pkg::FRAC_BITS_DEFAULT;
   localparam val_type V_MAX    = 48'sh7FFF_FFFF_FFFF;
   localparam val_type V_MIN    = 48'sh8000_0000_0000;
   localparam int      HOLD_LEN = 600;
   localparam int      WD_LIMIT = 4000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   abkf_req_if req_bus();
   abkf_rsp_if rsp_bus();
   abkf_csr_if csr_bus();

   angle_bias_kalman_filter u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #4 clock = ~clock;

   // filter state mirrored from accepted requests
   val_type est_angle, est_bias, p_aa, p_ab, p_ba, p_bb;
   val_type q_angle, q_bias, r_meas, dt_step;

   estimate_type pending_est[$];
   int           errors = 0;
   bit           quiet = 0;
   bit           hold_req = 0;
   bit           typed_now = 0;
   estimate_type typed_est;
   bit           next_typed = 0;
   estimate_type next_est;
   int           idle_cycles = 0;

   function automatic wide_type widen(input val_type v);
      return $signed({{80{v[abkf_pkg::VAL_W-1]}}, v});
   endfunction

   function automatic val_type clamp48(input wide_type v);
      if (v > widen(V_MAX)) return V_MAX;
      if (v < widen(V_MIN)) return V_MIN;
      return v[abkf_pkg::VAL_W-1:0];
   endfunction

   function automatic val_type add_q(input val_type a, input val_type b);
      return clamp48(widen(a) + widen(b));
   endfunction

   function automatic val_type sub_q(input val_type a, input val_type b);
      return clamp48(widen(a) - widen(b));
   endfunction

   function automatic val_type mul_q(input val_type a, input val_type b);
      wide_type p;
      p = widen(a) * widen(b);
      return clamp48(p >>> FRAC);
   endfunction

   function automatic val_type div_q(input val_type n, input val_type d);
      wide_type un, ud, q;
      bit       neg;
      if (d == 0) begin
         if (n == 0) return '0;
         return n > 0 ? V_MAX : V_MIN;
      end
      neg = (n < 0) != (d < 0);
      un  = n < 0 ? -widen(n) : widen(n);
      ud  = d < 0 ? -widen(d) : widen(d);
      q   = (un << FRAC) / ud;
      return clamp48(neg ? -q : q);
   endfunction

   task automatic filter_defaults();
      q_angle   = val_type'(((64'd1 << FRAC) + 64'd5000) / 64'd10000);
      q_bias    = val_type'(((64'd3 << FRAC) + 64'd500) / 64'd1000);
      r_meas    = val_type'(64'd20 << FRAC);
      dt_step   = val_type'(((64'd5 << FRAC) + 64'd500) / 64'd1000);
      est_angle = '0;
      est_bias  = '0;
      p_aa      = val_type'(64'd1 << FRAC);
      p_ab      = '0;
      p_ba      = '0;
      p_bb      = val_type'(64'd1 << FRAC);
   endtask

   function automatic estimate_type filter_sample(input val_type meas, input val_type gyro);
      val_type d0, d1, err, pc0, pc1, den, k0, k1, t1;
      estimate_type e;
      est_angle = add_q(est_angle, mul_q(sub_q(gyro, est_bias), dt_step));
      d0   = clamp48(widen(q_angle) - widen(p_ab) - widen(p_ba));
      d1   = clamp48(-widen(p_bb));
      p_aa = add_q(p_aa, mul_q(d0, dt_step));
      p_ab = add_q(p_ab, mul_q(d1, dt_step));
      p_ba = add_q(p_ba, mul_q(d1, dt_step));
      p_bb = add_q(p_bb, mul_q(q_bias, dt_step));
      err  = sub_q(meas, est_angle);
      pc0  = p_aa;
      pc1  = p_ba;
      den  = add_q(r_meas, pc0);
      k0   = div_q(pc0, den);
      k1   = div_q(pc1, den);
      t1   = p_ab;
      p_aa = sub_q(p_aa, mul_q(k0, pc0));
      p_ab = sub_q(p_ab, mul_q(k0, t1));
      p_ba = sub_q(p_ba, mul_q(k1, pc0));
      p_bb = sub_q(p_bb, mul_q(k1, t1));
      est_angle = add_q(est_angle, mul_q(k0, err));
      est_bias  = add_q(est_bias, mul_q(k1, err));
      e.angle = est_angle;
      e.rate  = sub_q(gyro, est_bias);
      return e;
   endfunction

   // request and response monitor
   always @(posedge clock) begin
      estimate_type got, want, pred;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            pred = filter_sample(req_bus.measured_angle, req_bus.gyro_rate);
            pending_est.push_back(typed_now ? typed_est : pred);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.angle = rsp_bus.angle_estimate;
            got.rate  = rsp_bus.corrected_rate;
            if (pending_est.size() == 0) begin
               $display("%0t: unexpected response angle %h rate %h", $time, got.angle,
                  got.rate);
               errors++;
            end else begin
               want = pending_est.pop_front();
               if (got.angle !== want.angle) begin
                  $display("%0t: angle_estimate expected %h actual %h", $time, want.angle,
                     got.angle);
                  errors++;
               end
               if (got.rate !== want.rate) begin
                  $display("%0t: corrected_rate expected %h actual %h", $time, want.rate,
                     got.rate);
                  errors++;
               end
            end
         end
      end
   end

   // response side stalls
   always @(negedge clock) begin
      int n;
      if (hold_req) begin
         rsp_bus.ready <= 1'b0;
         for (n = 0; n < HOLD_LEN - 1; n++) @(negedge clock);
         hold_req = 0;
      end else begin
         rsp_bus.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 14);
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready) || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WD_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic write_reg(input abkf_pkg::csr_index_type idx,
                            input logic [abkf_pkg::CFG_W-1:0] value);
      val_type v;
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      v = val_type'({1'b0, value});
      case (idx)
         abkf_pkg::CSR_ANGLE_NOISE: q_angle = v;
         abkf_pkg::CSR_BIAS_NOISE:  q_bias  = v;
         abkf_pkg::CSR_MEAS_NOISE:  r_meas  = v;
         abkf_pkg::CSR_PERIOD:      dt_step = v;
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic send_sample(input val_type meas, input val_type gyro);
      if (!quiet && $urandom_range(99) < 14) begin
         repeat ($urandom_range(4, 1)) begin
            @(negedge clock);
            req_bus.valid <= 1'b0;
         end
      end
      @(negedge clock);
      typed_now              = next_typed;
      typed_est              = next_est;
      req_bus.valid          <= 1'b1;
      req_bus.measured_angle <= meas;
      req_bus.gyro_rate      <= gyro;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic settle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      wait (pending_est.size() == 0);
      repeat (300) @(posedge clock);
   endtask

   function automatic val_type rand_value();
      logic [63:0] r;
      r = {$urandom, $urandom};
      case ($urandom_range(9))
         0:       return $urandom_range(1) ? V_MAX : V_MIN;
         1, 2, 3: return val_type'(r[47:0]);
         default: return val_type'($signed(r[39:0]));
      endcase
   endfunction

   function automatic logic [abkf_pkg::CFG_W-1:0] rand_reg();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return $urandom_range(1) ? r[abkf_pkg::CFG_W-1:0] : {15'd0, r[35:4]};
   endfunction

   stim_row_type stim_table[] = '{
      '{48'sd0, 48'sd0, 1'b1, '{48'sd0, 48'sd0}},
      '{48'sd0, 48'sd0, 1'b0, '{48'sd0, 48'sd0}},
      '{V_MAX, V_MAX, 1'b0, '{48'sd0, 48'sd0}},
      '{V_MIN, V_MIN, 1'b0, '{48'sd0, 48'sd0}},
      '{V_MAX, V_MIN, 1'b0, '{48'sd0, 48'sd0}},
      '{V_MIN, V_MAX, 1'b0, '{48'sd0, 48'sd0}},
      '{48'sh0000_0A00_0000, 48'sh0001_0000_0000, 1'b0, '{48'sd0, 48'sd0}},
      '{-48'sh0000_0A00_0000, -48'sh0001_0000_0000, 1'b0, '{48'sd0, 48'sd0}},
      '{48'sh5555_5555_5555, 48'shAAAA_AAAA_AAAA, 1'b0, '{48'sd0, 48'sd0}},
      '{48'shAAAA_AAAA_AAAA, 48'sh5555_5555_5555, 1'b0, '{48'sd0, 48'sd0}},
      '{48'sd1, -48'sd1, 1'b0, '{48'sd0, 48'sd0}},
      '{48'sh002D_0000_0000, 48'sd0, 1'b0, '{48'sd0, 48'sd0}}
   };

   initial begin
      int ph, k;
      req_bus.valid          = 1'b0;
      req_bus.measured_angle = '0;
      req_bus.gyro_rate      = '0;
      csr_bus.valid          = 1'b0;
      csr_bus.index          = abkf_pkg::CSR_ANGLE_NOISE;
      csr_bus.data           = '0;
      rsp_bus.ready          = 1'b0;
      filter_defaults();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_table[i]) begin
         next_typed = stim_table[i].typed;
         next_est   = stim_table[i].want;
         send_sample(stim_table[i].meas, stim_table[i].gyro);
      end
      next_typed = 0;
      settle();

      for (ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               write_reg(abkf_pkg::CSR_ANGLE_NOISE, '1);
               write_reg(abkf_pkg::CSR_BIAS_NOISE, '1);
               write_reg(abkf_pkg::CSR_MEAS_NOISE, '1);
               write_reg(abkf_pkg::CSR_PERIOD, '1);
            end
            1: begin
               write_reg(abkf_pkg::CSR_ANGLE_NOISE, '0);
               write_reg(abkf_pkg::CSR_BIAS_NOISE, '0);
               write_reg(abkf_pkg::CSR_MEAS_NOISE, 47'd1);
               write_reg(abkf_pkg::CSR_PERIOD, 47'd1);
            end
            2: begin
               write_reg(abkf_pkg::CSR_MEAS_NOISE, '0);
               write_reg(abkf_pkg::CSR_PERIOD, 47'h0000_4000_0000);
            end
            3, 4: begin
               write_reg(abkf_pkg::CSR_ANGLE_NOISE, rand_reg());
               write_reg(abkf_pkg::CSR_BIAS_NOISE, rand_reg());
               write_reg(abkf_pkg::CSR_MEAS_NOISE, rand_reg());
               write_reg(abkf_pkg::CSR_PERIOD, rand_reg());
            end
            default: begin
               write_reg(abkf_pkg::CSR_ANGLE_NOISE, 47'd429497);
               write_reg(abkf_pkg::CSR_BIAS_NOISE, 47'd12884902);
               write_reg(abkf_pkg::CSR_MEAS_NOISE, 47'd85899345920);
               write_reg(abkf_pkg::CSR_PERIOD, 47'd21474836);
            end
         endcase
         quiet = (ph == 4);
         for (k = 0; k < 82; k++) begin
            if (ph == 3 && k == 20) hold_req = 1;
            if (ph == 3 && k == 50) begin
               @(negedge clock);
               req_bus.valid <= 1'b0;
               wait (pending_est.size() == 0);
            end
            send_sample(rand_value(), rand_value());
         end
         quiet = 0;
         settle();
      end

      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
